// ----- hw/rtl/stt_pkg.sv -----
// Shared types, token kind codes and character class helpers for the tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  // Input operation codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  // Token kind codes
  localparam logic [4:0] KIND_INT    = 5'd0;
  localparam logic [4:0] KIND_DOUBLE = 5'd1;
  localparam logic [4:0] KIND_IDENT  = 5'd2;
  localparam logic [4:0] KIND_LET    = 5'd3;
  localparam logic [4:0] KIND_MUT    = 5'd4;
  localparam logic [4:0] KIND_PIPE   = 5'd5;
  localparam logic [4:0] KIND_ARROW  = 5'd6;
  localparam logic [4:0] KIND_COMMA  = 5'd7;
  localparam logic [4:0] KIND_PCT    = 5'd8;
  localparam logic [4:0] KIND_PLUS   = 5'd9;
  localparam logic [4:0] KIND_MINUS  = 5'd10;
  localparam logic [4:0] KIND_SLASH  = 5'd11;
  localparam logic [4:0] KIND_STAR   = 5'd12;
  localparam logic [4:0] KIND_ASSIGN = 5'd13;
  localparam logic [4:0] KIND_SEMI   = 5'd14;
  localparam logic [4:0] KIND_LPAREN = 5'd15;
  localparam logic [4:0] KIND_RPAREN = 5'd16;
  localparam logic [4:0] KIND_EOF    = 5'd17;

  // One token on its way out
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } stt_result_t;

  // Tokens produced by one input transaction, compacted into slot 0 first
  typedef struct packed {
    logic [1:0]  n;
    stt_result_t r0;
    stt_result_t r1;
  } stt_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  // Single-character tokens other than '='; valid bit in the MSB
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    k = 6'd0;
    case (c)
      ",": k = {1'b1, KIND_COMMA};
      "%": k = {1'b1, KIND_PCT};
      "+": k = {1'b1, KIND_PLUS};
      "-": k = {1'b1, KIND_MINUS};
      "/": k = {1'b1, KIND_SLASH};
      "*": k = {1'b1, KIND_STAR};
      ";": k = {1'b1, KIND_SEMI};
      "(": k = {1'b1, KIND_LPAREN};
      ")": k = {1'b1, KIND_RPAREN};
      default: k = 6'd0;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/stt_step.sv -----
// Input register, scanner state and per-byte token logic.
`timescale 1ns / 1ps

module stt_step #(
  parameter int PosBits = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [7:0]        character_i,
  input  logic              space_ok_i,
  output stt_pkg::stt_push_t push_o
);

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_NUM  = 5'b00010,
    MODE_ID   = 5'b00100,
    MODE_PIPE = 5'b01000,
    MODE_EQ   = 5'b10000
  } mode_e;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  // Saturate a position to the 16-bit output field
  function automatic logic [15:0] sat16(input logic [PosBits-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return (e > 32'h0000_FFFF) ? 16'hFFFF : e[15:0];
  endfunction

  // Input register
  logic       in_vld_q;
  logic       op_q;
  logic [7:0] chr_q;
  logic       take;

  assign take       = in_vld_q & space_ok_i;
  assign in_ready_o = ~in_vld_q | take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= operation_i;
      chr_q <= character_i;
    end
  end

  // Scanner state
  mode_e              mode_q, mode_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] start_q, start_d;
  logic [15:0]        len_q, len_d;
  logic               dot_q, dot_d;
  logic               let_q, let_d;
  logic               mut_q, mut_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      dot_q   <= 1'b0;
      let_q   <= 1'b0;
      mut_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      dot_q   <= dot_d;
      let_q   <= let_d;
      mut_q   <= mut_d;
    end
  end

  // Character classes of the current byte
  logic       c_digit, c_alpha, c_dot, c_gt;
  logic [5:0] c_single;

  assign c_digit  = stt_pkg::is_digit(chr_q);
  assign c_alpha  = stt_pkg::is_alpha(chr_q);
  assign c_dot    = (chr_q == ".");
  assign c_gt     = (chr_q == ">");
  assign c_single = stt_pkg::single_kind(chr_q);

  // Token held by the pending state, if any
  logic                fl_v;
  stt_pkg::stt_result_t fl;

  always_comb begin
    fl_v      = 1'b0;
    fl.kind   = stt_pkg::KIND_IDENT;
    fl.start  = sat16(start_q);
    fl.len    = len_q;
    fl.last   = 1'b0;
    case (mode_q)
      MODE_NUM: begin
        fl_v    = 1'b1;
        fl.kind = dot_q ? stt_pkg::KIND_DOUBLE : stt_pkg::KIND_INT;
      end
      MODE_ID: begin
        fl_v = 1'b1;
        if (len_q == 16'd3 && let_q) begin
          fl.kind = stt_pkg::KIND_LET;
        end else if (len_q == 16'd3 && mut_q) begin
          fl.kind = stt_pkg::KIND_MUT;
        end else begin
          fl.kind = stt_pkg::KIND_IDENT;
        end
      end
      MODE_EQ: begin
        fl_v    = 1'b1;
        fl.kind = stt_pkg::KIND_ASSIGN;
        fl.len  = 16'd1;
      end
      default: fl_v = 1'b0;
    endcase
  end

  // Next state and produced tokens
  logic                 a_v, b_v;
  stt_pkg::stt_result_t a, b;
  logic                 do_flush, do_start;
  logic [15:0]          len_inc;

  assign len_inc = (len_q != 16'hFFFF) ? len_q + 16'd1 : len_q;

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    dot_d    = dot_q;
    let_d    = let_q;
    mut_d    = mut_q;
    a_v      = 1'b0;
    a        = fl;
    b_v      = 1'b0;
    b.kind   = stt_pkg::KIND_EOF;
    b.start  = sat16(pos_q);
    b.len    = 16'd0;
    b.last   = 1'b0;
    do_flush = 1'b0;
    do_start = 1'b0;

    if (take) begin
      if (op_q == stt_pkg::OP_EOT) begin
        // End of text: flush, emit EOF, return to reset state
        a_v     = fl_v;
        b_v     = 1'b1;
        mode_d  = MODE_IDLE;
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
        dot_d   = 1'b0;
        let_d   = 1'b0;
        mut_d   = 1'b0;
      end else begin
        if (pos_q != PosMax) begin
          pos_d = pos_q + 1'b1;
        end
        case (mode_q)
          MODE_NUM: begin
            if (c_digit || c_dot) begin
              dot_d = dot_q | c_dot;
              len_d = len_inc;
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_ID: begin
            if (c_digit || c_alpha) begin
              if (len_q == 16'd1) begin
                let_d = let_q & (chr_q == "e");
                mut_d = mut_q & (chr_q == "u");
              end else if (len_q == 16'd2) begin
                let_d = let_q & (chr_q == "t");
                mut_d = mut_q & (chr_q == "t");
              end else begin
                let_d = 1'b0;
                mut_d = 1'b0;
              end
              len_d = len_inc;
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_PIPE: begin
            if (c_gt) begin
              a_v    = 1'b1;
              a.kind = stt_pkg::KIND_PIPE;
              a.len  = 16'd2;
              mode_d = MODE_IDLE;
            end else begin
              do_start = 1'b1;
            end
          end
          MODE_EQ: begin
            if (c_gt) begin
              a_v    = 1'b1;
              a.kind = stt_pkg::KIND_ARROW;
              a.len  = 16'd2;
              mode_d = MODE_IDLE;
            end else begin
              do_flush = 1'b1;
              do_start = 1'b1;
            end
          end
          default: do_start = 1'b1;
        endcase

        if (do_flush) begin
          a_v = fl_v;
        end

        // Open a new token on the current byte
        if (do_start) begin
          mode_d = MODE_IDLE;
          if (c_digit) begin
            mode_d  = MODE_NUM;
            start_d = pos_q;
            len_d   = 16'd1;
            dot_d   = 1'b0;
          end else if (c_alpha) begin
            mode_d  = MODE_ID;
            start_d = pos_q;
            len_d   = 16'd1;
            let_d   = (chr_q == "l");
            mut_d   = (chr_q == "m");
          end else if (chr_q == "|") begin
            mode_d  = MODE_PIPE;
            start_d = pos_q;
          end else if (chr_q == "=") begin
            mode_d  = MODE_EQ;
            start_d = pos_q;
          end else if (c_single[5]) begin
            b_v    = 1'b1;
            b.kind = c_single[4:0];
            b.len  = 16'd1;
          end
        end
      end
    end
  end

  // Compact tokens into the push slots and mark the last one
  always_comb begin
    push_o.n       = {1'b0, a_v} + {1'b0, b_v};
    push_o.r0      = a_v ? a : b;
    push_o.r0.last = ~(a_v & b_v);
    push_o.r1      = b;
    push_o.r1.last = 1'b1;
  end

endmodule

// ----- hw/rtl/stt_queue.sv -----
// Four-entry result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps

module stt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stt_pkg::stt_push_t   push_i,
  output logic                 space_ok_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stt_pkg::stt_result_t head_o
);

  stt_pkg::stt_result_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] wr_nxt;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign space_ok_o  = (cnt_q <= 3'd2);
  assign head_o      = mem_q[rd_q];
  assign wr_nxt      = wr_q + 2'd1;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.n;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_i.n} - {2'b00, pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

endmodule

// ----- hw/rtl/source_text_tokenizer.sv -----
// Top level of the streaming source text tokenizer.
// Throughput: one input byte per cycle while tokens drain at least as fast as produced;
//   an item may yield two tokens, which leave one per cycle through a four-entry queue.
// Tokens of a transaction enter the queue as the scan register takes it, behind any still queued.
// Reset: rst_ni clears scanner state, byte position and the queue; no tokens pending.
`timescale 1ns / 1ps

module source_text_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] start_position_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  stt_pkg::stt_push_t   push;
  stt_pkg::stt_result_t head;
  logic                 space_ok;

  // Scanner
  stt_step #(
    .PosBits(POSITION_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .character_i(character_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  // Result queue
  stt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign token_kind_o     = head.kind;
  assign start_position_o = head.start;
  assign token_length_o   = head.len;
  assign last_of_run_o    = head.last;

endmodule
